/* rtl/ucrd_pkg.sv */
package ucrd_pkg;

    localparam logic [1:0] RESP_ACK   = 2'd0;
    localparam logic [1:0] RESP_DATA  = 2'd1;
    localparam logic [1:0] RESP_STALL = 2'd2;

    localparam logic [15:0] RQ_SET_LINE_CODING      = 16'h2021;
    localparam logic [15:0] RQ_GET_LINE_CODING      = 16'h20A1;
    localparam logic [15:0] RQ_SET_CONTROL_LINE     = 16'h2221;
    localparam logic [15:0] RQ_SET_ADDRESS          = 16'h0500;
    localparam logic [15:0] RQ_SET_INTERFACE        = 16'h0B01;
    localparam logic [15:0] RQ_SET_CONFIGURATION    = 16'h0900;
    localparam logic [15:0] RQ_GET_CONFIGURATION    = 16'h0880;
    localparam logic [15:0] RQ_GET_STATUS_DEVICE    = 16'h0080;
    localparam logic [15:0] RQ_GET_STATUS_ENDPOINT  = 16'h0082;
    localparam logic [15:0] RQ_CLEAR_FEATURE_EP     = 16'h0102;
    localparam logic [15:0] RQ_SET_FEATURE_EP       = 16'h0302;
    localparam logic [15:0] RQ_DESC_LOOKUP          = 16'h0680;
    localparam logic [15:0] RQ_DESC_LOOKUP_IFACE    = 16'h0681;

    localparam logic [7:0] DESC_TYPE_STRING = 8'h03;

    localparam logic OP_SETUP       = 1'b0;
    localparam logic OP_TABLE_WRITE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_type;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
        logic [3:0]  entry_slot;
        logic [15:0] entry_key;
        logic [15:0] entry_length;
        logic [7:0]  entry_first_byte;
        logic        entry_valid;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  response;
        logic        from_table;
        logic [3:0]  table_slot;
        logic [15:0] send_length;
        logic [7:0]  reply_byte;
        logic        address_strobe;
        logic [7:0]  new_address;
        logic        connect_strobe;
        logic        connected;
    } out_item_t;

    // what one cell reports while it holds the search token
    typedef struct packed {
        logic        hit;
        logic        stop;
        logic [15:0] len;
    } cell_stat_t;

    function automatic out_item_t emit_data(out_item_t r, logic [15:0] len,
                                            logic [15:0] limit, logic tab,
                                            logic [3:0] slot, logic [7:0] byte0);
        out_item_t   o;
        logic [15:0] n;
        o = r;
        n = (len > limit) ? limit : len;
        if (n != 16'd0)
        begin
            o.response    = RESP_DATA;
            o.from_table  = tab;
            o.table_slot  = tab ? slot : 4'd0;
            o.send_length = n;
            o.reply_byte  = byte0;
        end
        return o;
    endfunction

    // every request other than a descriptor lookup
    function automatic out_item_t decode_std(logic [15:0] rt, logic [15:0] wv,
                                             logic [15:0] wi, logic [15:0] wl,
                                             logic [7:0] cfg);
        out_item_t r;
        r = '0;
        r.response = RESP_ACK;
        case (rt)
            RQ_SET_LINE_CODING, RQ_GET_LINE_CODING, RQ_SET_INTERFACE,
            RQ_SET_CONFIGURATION:
            begin
                r.response = RESP_ACK;
            end
            RQ_SET_CONTROL_LINE:
            begin
                r.connect_strobe = 1'b1;
                r.connected      = wv[0];
            end
            RQ_SET_ADDRESS:
            begin
                r.address_strobe = 1'b1;
                r.new_address    = wv[7:0];
            end
            RQ_GET_CONFIGURATION:
            begin
                r = emit_data(r, 16'd1, wl, 1'b0, 4'd0, cfg);
            end
            RQ_GET_STATUS_DEVICE:
            begin
                r = emit_data(r, 16'd2, wl, 1'b0, 4'd0, 8'd0);
            end
            RQ_GET_STATUS_ENDPOINT:
            begin
                if (wi != 16'd0)
                    r.response = RESP_STALL;
                else
                    r = emit_data(r, 16'd2, wl, 1'b0, 4'd0, 8'd0);
            end
            RQ_CLEAR_FEATURE_EP, RQ_SET_FEATURE_EP:
            begin
                if (wi != 16'd0 || wv != 16'd0)
                    r.response = RESP_STALL;
            end
            default:
            begin
                r.response = RESP_STALL;
            end
        endcase
        return r;
    endfunction

endpackage

/* rtl/ucrd_cell.sv */
module ucrd_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  ucrd_pkg::in_item_t   wr_item,
    input  logic [15:0]          search_key,
    input  logic                 use_first_byte,
    input  logic                 tok_in,
    output logic                 tok_out,
    output ucrd_pkg::cell_stat_t stat
);

    logic        valid_reg;
    logic [15:0] key_reg;
    logic [15:0] len_reg;
    logic [7:0]  first_byte_reg;
    logic        tok_reg;
    logic        match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (wr_en)
                valid_reg <= wr_item.entry_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_reg        <= wr_item.entry_key;
            len_reg        <= wr_item.entry_length;
            first_byte_reg <= wr_item.entry_first_byte;
        end
    end

    assign match     = (key_reg == search_key);
    assign stat.hit  = tok_reg && valid_reg && match;
    assign stat.stop = tok_reg && !valid_reg;
    assign stat.len  = use_first_byte ? {8'd0, first_byte_reg} : len_reg;
    // token moves on to the next slot when this one is valid but not the key
    assign tok_out   = tok_reg && valid_reg && !match;

endmodule

/* rtl/usb_control_request_decoder_top.sv */
// channel | direction | handshake        | payload
// in      | input     | in_valid/in_stall   | in_item  (ucrd_pkg::in_item_t)
// out     | output    | out_valid/out_stall | out_item (ucrd_pkg::out_item_t)
//
// a table write gives no result
// a setup item's result goes to res_reg, then to the output register in ST_EMIT;
// a descriptor lookup first moves the search token slot by slot in ST_SCAN
// one item at a time: in_stall is high from acceptance until the result is
// loaded into the output register, which then holds it while out_stall is high
// reset clears the valid bit of every slot and the active configuration
module usb_control_request_decoder_top #(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ucrd_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output ucrd_pkg::out_item_t out_item
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic [7:0]           cfg_reg, cfg_next;
    logic [15:0]          wv_reg, wv_next;
    logic [15:0]          wl_reg, wl_next;
    ucrd_pkg::out_item_t  res_reg, res_next;
    ucrd_pkg::out_item_t  out_item_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;

    logic                 in_fire;
    logic                 start;
    logic                 use_first_byte;
    logic                 is_desc;
    logic [TABLE_ENTRIES-1:0] wr_en;
    logic [TABLE_ENTRIES-1:0] tok_in;
    logic [TABLE_ENTRIES-1:0] tok_out;
    ucrd_pkg::cell_stat_t stat [TABLE_ENTRIES];

    logic                 scan_hit;
    logic                 scan_end;
    logic [15:0]          hit_len;
    logic [3:0]           hit_slot;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign is_desc   = (in_item.request_type == ucrd_pkg::RQ_DESC_LOOKUP) ||
                       (in_item.request_type == ucrd_pkg::RQ_DESC_LOOKUP_IFACE);
    assign start     = in_fire && (in_item.operation == ucrd_pkg::OP_SETUP) && is_desc;
    assign use_first_byte = (wv_reg[15:8] == ucrd_pkg::DESC_TYPE_STRING);

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++)
        begin : g_cell
            assign wr_en[g] = in_fire && (in_item.operation == ucrd_pkg::OP_TABLE_WRITE)
                              && (32'(in_item.entry_slot) == g);
            if (g == 0)
            begin : g_head
                assign tok_in[g] = start;
            end
            else
            begin : g_link
                assign tok_in[g] = tok_out[g-1];
            end
            ucrd_cell u_cell (
                .clk            (clk),
                .rst_n          (rst_n),
                .wr_en          (wr_en[g]),
                .wr_item        (in_item),
                .search_key     (wv_reg),
                .use_first_byte (use_first_byte),
                .tok_in         (tok_in[g]),
                .tok_out        (tok_out[g]),
                .stat           (stat[g])
            );
        end
    endgenerate

    // only one cell holds the token, so these merges are one-hot
    always_comb
    begin
        scan_hit = 1'b0;
        scan_end = tok_out[TABLE_ENTRIES-1];
        hit_len  = '0;
        hit_slot = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (stat[i].hit)
            begin
                scan_hit = 1'b1;
                hit_len  = hit_len | stat[i].len;
                hit_slot = hit_slot | 4'(i);
            end
            if (stat[i].stop)
                scan_end = 1'b1;
        end
    end

    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        cfg_next       = cfg_reg;
        wv_next        = wv_reg;
        wl_next        = wl_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && in_item.operation == ucrd_pkg::OP_SETUP)
                begin
                    wv_next = in_item.request_value;
                    wl_next = in_item.request_length;
                    if (is_desc)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        res_next = ucrd_pkg::decode_std(in_item.request_type,
                                                        in_item.request_value,
                                                        in_item.request_index,
                                                        in_item.request_length,
                                                        cfg_reg);
                        if (in_item.request_type == ucrd_pkg::RQ_SET_CONFIGURATION)
                            cfg_next = in_item.request_value[7:0];
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_next = ucrd_pkg::emit_data('0, hit_len, wl_reg, 1'b1,
                                                   hit_slot, 8'd0);
                    state_next = ST_EMIT;
                end
                else if (scan_end)
                begin
                    res_next          = '0;
                    res_next.response = ucrd_pkg::RESP_STALL;
                    state_next        = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wv_reg  <= wv_next;
        wl_reg  <= wl_next;
        res_reg <= res_next;
        if (out_load)
            out_item_reg <= res_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_tok_onehot_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> $onehot(tok_out) || $onehot({scan_hit, scan_end}))
        else $error("search token lost or duplicated");

    a_no_tok_outside_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (tok_out == '0) && !scan_hit && !scan_end)
        else $error("search token outside a scan");

    a_hit_end_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(scan_hit && scan_end))
        else $error("scan reports both a hit and an end");

    a_accept_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_IDLE) || (state_reg == ST_SCAN)
            || (state_reg == ST_EMIT && !$past(is_desc)))
        else $error("unexpected state after an accepted item");

endmodule

/* test/usb_control_request_decoder_top_tb.sv */
module usb_control_request_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SIZE = 16;
    localparam int RANDOM_ITEMS = 1350;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    ucrd_pkg::in_item_t  in_item = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    ucrd_pkg::out_item_t out_item;

    usb_control_request_decoder_top #(
        .TABLE_ENTRIES(TABLE_SIZE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item (out_item)
    );

    // device state as the decoder should hold it
    logic [7:0]  active_cfg;
    logic [15:0] desc_key     [TABLE_SIZE];
    logic [15:0] desc_len     [TABLE_SIZE];
    logic [7:0]  desc_first   [TABLE_SIZE];
    logic        desc_present [TABLE_SIZE];

    ucrd_pkg::in_item_t  items_to_send [$];
    ucrd_pkg::out_item_t pending_replies [$];
    logic [15:0]         known_requests [14];

    int unsigned fail_count = 0;
    int unsigned replies_seen = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    int unsigned holds_taken = 0;
    int unsigned rx_cycle = 0;
    int unsigned rx_mode = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // clamp a reply to wLength; nothing left to send means a plain ack
    function automatic ucrd_pkg::out_item_t data_reply(logic [15:0] len, logic [15:0] limit,
                                                       logic tab, logic [3:0] slot,
                                                       logic [7:0] first);
        ucrd_pkg::out_item_t r;
        r = '0;
        r.response = ucrd_pkg::RESP_ACK;
        if (len > limit)
            len = limit;
        if (len != 16'd0)
        begin
            r.response    = ucrd_pkg::RESP_DATA;
            r.from_table  = tab;
            r.table_slot  = tab ? slot : 4'd0;
            r.send_length = len;
            r.reply_byte  = first;
        end
        return r;
    endfunction

    task automatic apply_item(input ucrd_pkg::in_item_t it);
        ucrd_pkg::out_item_t r;
        logic [15:0]         len;
        int                  s;
        if (it.operation == ucrd_pkg::OP_TABLE_WRITE)
        begin
            if (int'(it.entry_slot) < TABLE_SIZE)
            begin
                desc_key[it.entry_slot]     = it.entry_key;
                desc_len[it.entry_slot]     = it.entry_length;
                desc_first[it.entry_slot]   = it.entry_first_byte;
                desc_present[it.entry_slot] = it.entry_valid;
            end
            return;
        end
        r = '0;
        r.response = ucrd_pkg::RESP_ACK;
        case (it.request_type)
            ucrd_pkg::RQ_SET_LINE_CODING, ucrd_pkg::RQ_GET_LINE_CODING,
            ucrd_pkg::RQ_SET_INTERFACE:
            begin
            end
            ucrd_pkg::RQ_SET_CONTROL_LINE:
            begin
                r.connect_strobe = 1'b1;
                r.connected      = it.request_value[0];
            end
            ucrd_pkg::RQ_SET_ADDRESS:
            begin
                r.address_strobe = 1'b1;
                r.new_address    = it.request_value[7:0];
            end
            ucrd_pkg::RQ_SET_CONFIGURATION:
            begin
                active_cfg = it.request_value[7:0];
            end
            ucrd_pkg::RQ_GET_CONFIGURATION:
            begin
                r = data_reply(16'd1, it.request_length, 1'b0, 4'd0, active_cfg);
            end
            ucrd_pkg::RQ_GET_STATUS_DEVICE:
            begin
                r = data_reply(16'd2, it.request_length, 1'b0, 4'd0, 8'd0);
            end
            ucrd_pkg::RQ_GET_STATUS_ENDPOINT:
            begin
                if (it.request_index != 16'd0)
                    r.response = ucrd_pkg::RESP_STALL;
                else
                    r = data_reply(16'd2, it.request_length, 1'b0, 4'd0, 8'd0);
            end
            ucrd_pkg::RQ_CLEAR_FEATURE_EP, ucrd_pkg::RQ_SET_FEATURE_EP:
            begin
                if (it.request_index != 16'd0 || it.request_value != 16'd0)
                    r.response = ucrd_pkg::RESP_STALL;
            end
            ucrd_pkg::RQ_DESC_LOOKUP, ucrd_pkg::RQ_DESC_LOOKUP_IFACE:
            begin
                // walk the list until a hole or a key match
                s = 0;
                while (s < TABLE_SIZE && desc_present[s] && desc_key[s] != it.request_value)
                    s++;
                if (s < TABLE_SIZE && desc_present[s])
                begin
                    len = (it.request_value[15:8] == ucrd_pkg::DESC_TYPE_STRING) ?
                          {8'h00, desc_first[s]} : desc_len[s];
                    r = data_reply(len, it.request_length, 1'b1, 4'(s), 8'd0);
                end
                else
                begin
                    r.response = ucrd_pkg::RESP_STALL;
                end
            end
            default:
            begin
                r.response = ucrd_pkg::RESP_STALL;
            end
        endcase
        pending_replies.push_back(r);
    endtask

    task automatic note_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
        fail_count++;
        if (fail_count <= 10)
            $display("reply %0d: %s expected %0h got %0h", replies_seen, what, want, got);
    endtask

    task automatic check_reply(input ucrd_pkg::out_item_t got);
        ucrd_pkg::out_item_t want;
        if (pending_replies.size() == 0)
        begin
            note_mismatch("unexpected reply", 64'd0, 64'(got));
            return;
        end
        want = pending_replies.pop_front();
        if (got.response !== want.response)
            note_mismatch("response", 64'(want.response), 64'(got.response));
        if (got.from_table !== want.from_table)
            note_mismatch("from_table", 64'(want.from_table), 64'(got.from_table));
        if (got.table_slot !== want.table_slot)
            note_mismatch("table_slot", 64'(want.table_slot), 64'(got.table_slot));
        if (got.send_length !== want.send_length)
            note_mismatch("send_length", 64'(want.send_length), 64'(got.send_length));
        if (got.reply_byte !== want.reply_byte)
            note_mismatch("reply_byte", 64'(want.reply_byte), 64'(got.reply_byte));
        if (got.address_strobe !== want.address_strobe)
            note_mismatch("address_strobe", 64'(want.address_strobe),
                          64'(got.address_strobe));
        if (got.new_address !== want.new_address)
            note_mismatch("new_address", 64'(want.new_address), 64'(got.new_address));
        if (got.connect_strobe !== want.connect_strobe)
            note_mismatch("connect_strobe", 64'(want.connect_strobe),
                          64'(got.connect_strobe));
        if (got.connected !== want.connected)
            note_mismatch("connected", 64'(want.connected), 64'(got.connected));
    endtask

    task automatic push_setup(input logic [15:0] rt, input logic [15:0] wv,
                              input logic [15:0] wi, input logic [15:0] wl);
        ucrd_pkg::in_item_t it;
        it.operation        = ucrd_pkg::OP_SETUP;
        it.request_type     = rt;
        it.request_value    = wv;
        it.request_index    = wi;
        it.request_length   = wl;
        it.entry_slot       = 4'($urandom);
        it.entry_key        = 16'($urandom);
        it.entry_length     = 16'($urandom);
        it.entry_first_byte = 8'($urandom);
        it.entry_valid      = 1'($urandom);
        items_to_send.push_back(it);
    endtask

    task automatic push_entry(input logic [3:0] slot, input logic [15:0] key,
                              input logic [15:0] len, input logic [7:0] first,
                              input logic present);
        ucrd_pkg::in_item_t it;
        it.operation        = ucrd_pkg::OP_TABLE_WRITE;
        it.request_type     = 16'($urandom);
        it.request_value    = 16'($urandom);
        it.request_index    = 16'($urandom);
        it.request_length   = 16'($urandom);
        it.entry_slot       = slot;
        it.entry_key        = key;
        it.entry_length     = len;
        it.entry_first_byte = first;
        it.entry_valid      = present;
        items_to_send.push_back(it);
    endtask

    // keys from a small pool so that lookups hit often
    function automatic logic [15:0] pick_key();
        if ($urandom_range(0, 7) == 0)
            return 16'($urandom);
        return {8'($urandom_range(1, 4)), 8'($urandom_range(0, 3))};
    endfunction

    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 4))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 8));
            2: return 16'($urandom_range(9, 300));
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'($urandom_range(1, 4));
            2: return 16'($urandom_range(5, 300));
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // sender: bursts of items with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                apply_item(in_item);
            if (in_valid && in_stall)
            begin
                // hold the item until taken
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (items_to_send.size() != 0)
            begin
                in_valid <= 1'b1;
                in_item  <= items_to_send.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
                else
                begin
                    burst_left <= burst_left - 1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall pattern set when rx_cycle[5:0] is 0, plus two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall   <= 1'b0;
            hold_left   <= 0;
            holds_taken <= 0;
            rx_cycle    <= 0;
            rx_mode     <= 0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle[5:0] == 6'd0)
                rx_mode <= $urandom_range(0, 3);
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if ((holds_taken == 0 && replies_seen >= 150) ||
                     (holds_taken == 1 && replies_seen >= 800))
            begin
                out_stall   <= 1'b1;
                hold_left   <= $urandom_range(300, 500);
                holds_taken <= holds_taken + 1;
            end
            else
            begin
                case (rx_mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'($urandom_range(0, 1));
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= rx_cycle[2];
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            check_reply(out_item);
            replies_seen <= replies_seen + 1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int unsigned pick;
        int unsigned fill;
        logic [15:0] rt;
        logic [15:0] wv;
        logic [15:0] wi;

        active_cfg = 8'd0;
        for (int s = 0; s < TABLE_SIZE; s++)
        begin
            desc_key[s]     = 16'd0;
            desc_len[s]     = 16'd0;
            desc_first[s]   = 8'd0;
            desc_present[s] = 1'b0;
        end
        known_requests = '{ucrd_pkg::RQ_SET_LINE_CODING, ucrd_pkg::RQ_GET_LINE_CODING,
                           ucrd_pkg::RQ_SET_CONTROL_LINE, ucrd_pkg::RQ_SET_ADDRESS,
                           ucrd_pkg::RQ_SET_INTERFACE, ucrd_pkg::RQ_SET_CONFIGURATION,
                           ucrd_pkg::RQ_GET_CONFIGURATION, ucrd_pkg::RQ_GET_STATUS_DEVICE,
                           ucrd_pkg::RQ_GET_STATUS_ENDPOINT, ucrd_pkg::RQ_CLEAR_FEATURE_EP,
                           ucrd_pkg::RQ_SET_FEATURE_EP, ucrd_pkg::RQ_DESC_LOOKUP,
                           ucrd_pkg::RQ_DESC_LOOKUP_IFACE, 16'hFFFF};

        // directed: descriptor list with a hole after slot 4
        push_entry(4'd0, 16'h0100, 16'd18, 8'd18, 1'b1);
        push_entry(4'd1, 16'h0200, 16'd67, 8'd9, 1'b1);
        push_entry(4'd2, 16'h0300, 16'd0, 8'd4, 1'b1);
        push_entry(4'd3, 16'h0301, 16'd100, 8'hFF, 1'b1);
        push_entry(4'd4, 16'hFFFF, 16'hFFFF, 8'h00, 1'b1);
        push_entry(4'd5, 16'h0600, 16'd10, 8'd10, 1'b0);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'h0100, 16'd0, 16'hFFFF);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP_IFACE, 16'h0200, 16'hFFFF, 16'd9);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'h0300, 16'd0, 16'd255);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'h0301, 16'd0, 16'hFFFF);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'hFFFF, 16'd0, 16'hFFFF);
        // key sits in the invalid slot that forms the hole, so no match
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'h0600, 16'd0, 16'hFFFF);
        push_setup(ucrd_pkg::RQ_DESC_LOOKUP, 16'h0100, 16'd0, 16'd0);
        push_setup(ucrd_pkg::RQ_SET_CONFIGURATION, 16'hABCD, 16'd0, 16'd0);
        push_setup(ucrd_pkg::RQ_GET_CONFIGURATION, 16'd0, 16'd0, 16'd1);
        push_setup(ucrd_pkg::RQ_SET_ADDRESS, 16'hFF7F, 16'd0, 16'd0);
        push_setup(ucrd_pkg::RQ_SET_CONTROL_LINE, 16'h0001, 16'd0, 16'd0);
        push_setup(ucrd_pkg::RQ_SET_LINE_CODING, 16'd0, 16'd0, 16'd7);
        push_setup(ucrd_pkg::RQ_GET_LINE_CODING, 16'd0, 16'd0, 16'd7);
        push_setup(ucrd_pkg::RQ_SET_INTERFACE, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_setup(ucrd_pkg::RQ_GET_STATUS_DEVICE, 16'd0, 16'd0, 16'd1);
        push_setup(ucrd_pkg::RQ_GET_STATUS_ENDPOINT, 16'd0, 16'd0, 16'hFFFF);
        push_setup(ucrd_pkg::RQ_GET_STATUS_ENDPOINT, 16'd0, 16'h8000, 16'd2);
        push_setup(ucrd_pkg::RQ_CLEAR_FEATURE_EP, 16'd1, 16'd0, 16'd0);
        push_setup(ucrd_pkg::RQ_SET_FEATURE_EP, 16'd0, 16'd0, 16'd0);
        push_setup(16'hFFFF, 16'd0, 16'd0, 16'hFFFF);

        while (items_to_send.size() < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // rebuild the list from slot 0, sometimes all slots valid
                fill = $urandom_range(1, TABLE_SIZE);
                for (int k = 0; k < fill; k++)
                    push_entry(4'(k), pick_key(), pick_len(), 8'($urandom), 1'b1);
                if (fill < TABLE_SIZE && $urandom_range(0, 3) != 0)
                    push_entry(4'(fill), 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
            end
            else if (pick < 16)
            begin
                push_entry(4'($urandom), pick_key(), pick_len(), 8'($urandom),
                           1'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 4) == 0)
                    rt = 16'($urandom);
                else if ($urandom_range(0, 2) == 0)
                    rt = $urandom_range(0, 1) ? ucrd_pkg::RQ_DESC_LOOKUP
                                              : ucrd_pkg::RQ_DESC_LOOKUP_IFACE;
                else
                    rt = known_requests[4'($urandom_range(0, 13))];
                if (rt == ucrd_pkg::RQ_DESC_LOOKUP || rt == ucrd_pkg::RQ_DESC_LOOKUP_IFACE)
                    wv = pick_key();
                else if ($urandom_range(0, 2) == 0)
                    wv = 16'd0;
                else
                    wv = 16'($urandom);
                wi = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                push_setup(rt, wv, wi, pick_limit());
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_to_send.size() != 0 || in_valid || pending_replies.size() != 0)
            @(posedge clk);
        repeat (4 * TABLE_SIZE) @(posedge clk);

        if (fail_count == 0 && pending_replies.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
